// ----- hw/rtl/lrx_pkg.sv -----
package lrx_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int SYM_W          = 8;

  localparam logic [SYM_W-1:0] CH_NUL    = 8'h00;
  localparam logic [SYM_W-1:0] CH_TIMES  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [SYM_W-1:0] CH_DIVIDE = 8'h2F;
  localparam logic [SYM_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    OP_PLUS    = 3'd0,
    OP_MINUS   = 3'd1,
    OP_TIMES   = 3'd2,
    OP_DIVIDE  = 3'd3,
    OP_UNKNOWN = 3'd4
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic ld_digit;
    logic set_op;
    logic apply;
    logic start;
    logic step;
    logic finish;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_digit;
    logic is_term;
    logic needs_unit;
    logic unit_last;
  } sts_t;

  function automatic op_t encode_op(input logic [SYM_W-1:0] sym);
    op_t op;
    unique case (sym)
      CH_PLUS:   op = OP_PLUS;
      CH_MINUS:  op = OP_MINUS;
      CH_TIMES:  op = OP_TIMES;
      CH_DIVIDE: op = OP_DIVIDE;
      default:   op = OP_UNKNOWN;
    endcase
    return op;
  endfunction

endpackage

// ----- hw/rtl/left_to_right_expression_evaluator_core.sv -----
// Digits are taken without leaving the idle state; so is a non-digit that applies a
// pending '+', '-', unknown operator or a division by zero. A non-digit that applies a
// pending '*' or '/' runs the one-bit-per-cycle shift-add / restoring-division unit and
// then a finish step; input is stalled meanwhile. A zero byte also passes an emit step
// that loads the output register (and waits while it is full). Synchronous active-low
// reset clears total, number, error flag and output valid; pending operator is plus.
module left_to_right_expression_evaluator_core #(
  parameter int DATA_WIDTH = lrx_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lrx_pkg::SYM_W-1:0]          in_symbol,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [lrx_pkg::VALUE_W-1:0] out_value,
  output logic                               out_divide_error
);

  lrx_pkg::cmd_t cmd;
  lrx_pkg::sts_t sts;

  lrx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lrx_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_symbol        (in_symbol),
    .cmd              (cmd),
    .sts              (sts),
    .out_value        (out_value),
    .out_divide_error (out_divide_error)
  );

endmodule

// ----- hw/rtl/lrx_ctrl.sv -----
module lrx_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  lrx_pkg::sts_t sts,
  output lrx_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_FIN  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   term_r, term_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (sts.is_digit) begin
            cmd.ld_digit = 1'b1;
          end else begin
            cmd.set_op = 1'b1;
            term_nxt   = sts.is_term;
            if (sts.needs_unit) begin
              cmd.start = 1'b1;
              state_nxt = S_RUN;
            end else begin
              cmd.apply = 1'b1;
              if (sts.is_term) state_nxt = S_EMIT;
            end
          end
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (sts.unit_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = term_r ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // hold until the output register can take the transaction
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.emit | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      term_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/lrx_dpath.sv -----
module lrx_dpath #(
  parameter int DATA_WIDTH = lrx_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [lrx_pkg::SYM_W-1:0]        in_symbol,
  input  lrx_pkg::cmd_t                    cmd,
  output lrx_pkg::sts_t                    sts,
  output logic signed [lrx_pkg::VALUE_W-1:0] out_value,
  output logic                             out_divide_error
);

  localparam int CNT_W = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] total_r, total_nxt;
  logic [DATA_WIDTH-1:0] num_r, num_nxt;
  lrx_pkg::op_t          pend_r, pend_nxt;
  logic                  err_r, err_nxt;

  // shared iterative multiply / divide unit
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] opa_r, opa_nxt;
  logic [DATA_WIDTH-1:0] opb_r, opb_nxt;
  logic                  div_r, div_nxt;
  logic                  neg_r, neg_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  logic [lrx_pkg::VALUE_W-1:0] value_r, value_nxt;
  logic                        derr_r, derr_nxt;

  logic [DATA_WIDTH-1:0] digit;
  logic [DATA_WIDTH-1:0] tot_mag;
  logic [DATA_WIDTH-1:0] num_mag;
  logic [DATA_WIDTH:0]   trial;
  logic                  fits;
  logic                  num_zero;

  assign sts.is_digit   = (in_symbol >= lrx_pkg::CH_ZERO) && (in_symbol <= lrx_pkg::CH_NINE);
  assign sts.is_term    = (in_symbol == lrx_pkg::CH_NUL);
  assign num_zero       = (num_r == '0);
  assign sts.needs_unit = (pend_r == lrx_pkg::OP_TIMES) ||
                          ((pend_r == lrx_pkg::OP_DIVIDE) && !num_zero);
  assign sts.unit_last  = (cnt_r == '0);

  // low nibble of an ASCII digit is its value
  assign digit   = DATA_WIDTH'(in_symbol[3:0]);
  assign tot_mag = total_r[DATA_WIDTH-1] ? (~total_r + 1'b1) : total_r;
  assign num_mag = num_r[DATA_WIDTH-1] ? (~num_r + 1'b1) : num_r;
  assign trial   = {acc_r, opa_r[DATA_WIDTH-1]};
  assign fits    = (trial >= {1'b0, opb_r});

  always_comb begin
    total_nxt = total_r;
    num_nxt   = num_r;
    pend_nxt  = pend_r;
    err_nxt   = err_r;
    acc_nxt   = acc_r;
    opa_nxt   = opa_r;
    opb_nxt   = opb_r;
    div_nxt   = div_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    value_nxt = value_r;
    derr_nxt  = derr_r;

    if (cmd.ld_digit) begin
      num_nxt = (num_r << 3) + (num_r << 1) + digit;
    end

    if (cmd.apply) begin
      case (pend_r)
        lrx_pkg::OP_PLUS:   total_nxt = total_r + num_r;
        lrx_pkg::OP_MINUS:  total_nxt = total_r - num_r;
        lrx_pkg::OP_DIVIDE: err_nxt   = 1'b1;  // only reached with a zero divisor
        default:            total_nxt = total_r;
      endcase
    end

    if (cmd.set_op) begin
      pend_nxt = lrx_pkg::encode_op(in_symbol);
      num_nxt  = '0;
    end

    if (cmd.start) begin
      div_nxt = (pend_r == lrx_pkg::OP_DIVIDE);
      neg_nxt = total_r[DATA_WIDTH-1] ^ num_r[DATA_WIDTH-1];
      acc_nxt = '0;
      cnt_nxt = CNT_W'(DATA_WIDTH - 1);
      if (pend_r == lrx_pkg::OP_DIVIDE) begin
        opa_nxt = tot_mag;
        opb_nxt = num_mag;
      end else begin
        opa_nxt = total_r;
        opb_nxt = num_r;
      end
    end

    if (cmd.step) begin
      cnt_nxt = cnt_r - 1'b1;
      if (div_r) begin
        acc_nxt = fits ? DATA_WIDTH'(trial - {1'b0, opb_r}) : trial[DATA_WIDTH-1:0];
        opa_nxt = {opa_r[DATA_WIDTH-2:0], fits};
      end else begin
        acc_nxt = opb_r[0] ? (acc_r + opa_r) : acc_r;
        opa_nxt = opa_r << 1;
        opb_nxt = opb_r >> 1;
      end
    end

    if (cmd.finish) begin
      if (div_r) total_nxt = neg_r ? (~opa_r + 1'b1) : opa_r;
      else       total_nxt = acc_r;
    end

    if (cmd.emit) begin
      value_nxt = lrx_pkg::VALUE_W'(total_r);
      derr_nxt  = err_r;
      total_nxt = '0;
      num_nxt   = '0;
      pend_nxt  = lrx_pkg::OP_PLUS;
      err_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      num_r   <= '0;
      pend_r  <= lrx_pkg::OP_PLUS;
      err_r   <= 1'b0;
    end else begin
      total_r <= total_nxt;
      num_r   <= num_nxt;
      pend_r  <= pend_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    opa_r   <= opa_nxt;
    opb_r   <= opb_nxt;
    div_r   <= div_nxt;
    neg_r   <= neg_nxt;
    cnt_r   <= cnt_nxt;
    value_r <= value_nxt;
    derr_r  <= derr_nxt;
  end

  assign out_value        = $signed(value_r);
  assign out_divide_error = derr_r;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int ITEM_TARGET  = 1750;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS  = 10;
  localparam int RESET_CYCLES = 9;
  localparam logic [lrx_pkg::SYM_W-1:0] CH_ALL_ONES = 8'hFF;

  typedef struct packed {
    logic [lrx_pkg::VALUE_W-1:0] value;
    logic                        div_err;
  } total_t;

  typedef struct packed {
    logic [lrx_pkg::SYM_W-1:0]   sym;
    logic                        typed;
    logic [lrx_pkg::VALUE_W-1:0] value;
    logic                        div_err;
  } row_t;

  logic                               clk       = 1'b0;
  logic                               rst_n     = 1'b0;
  logic                               in_valid  = 1'b0;
  logic                               in_stall;
  logic [lrx_pkg::SYM_W-1:0]          in_symbol = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [lrx_pkg::VALUE_W-1:0] out_value;
  logic                               out_divide_error;

  // Evaluator state as seen by the predictor
  logic [lrx_pkg::VALUE_W-1:0] acc_total;
  logic [lrx_pkg::VALUE_W-1:0] acc_number;
  lrx_pkg::op_t                acc_op;
  logic                        acc_div_err;

  total_t totals_due[$];
  int     items_sent     = 0;
  int     mismatches     = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;

  // Typed-in totals: empty expression, most negative over minus one with a
  // discarded number after an unknown operator, and a division by zero.
  row_t directed_rows [33] = '{
    '{lrx_pkg::CH_NUL,    1'b1, 32'd0,        1'b0},
    '{"2",                1'b0, 32'd0,        1'b0},
    '{"1",                1'b0, 32'd0,        1'b0},
    '{"4",                1'b0, 32'd0,        1'b0},
    '{"7",                1'b0, 32'd0,        1'b0},
    '{"4",                1'b0, 32'd0,        1'b0},
    '{"8",                1'b0, 32'd0,        1'b0},
    '{"3",                1'b0, 32'd0,        1'b0},
    '{"6",                1'b0, 32'd0,        1'b0},
    '{"4",                1'b0, 32'd0,        1'b0},
    '{"8",                1'b0, 32'd0,        1'b0},
    '{lrx_pkg::CH_DIVIDE, 1'b0, 32'd0,        1'b0},
    '{"4",                1'b0, 32'd0,        1'b0},
    '{"2",                1'b0, 32'd0,        1'b0},
    '{"9",                1'b0, 32'd0,        1'b0},
    '{"4",                1'b0, 32'd0,        1'b0},
    '{"9",                1'b0, 32'd0,        1'b0},
    '{"6",                1'b0, 32'd0,        1'b0},
    '{"7",                1'b0, 32'd0,        1'b0},
    '{"2",                1'b0, 32'd0,        1'b0},
    '{"9",                1'b0, 32'd0,        1'b0},
    '{"5",                1'b0, 32'd0,        1'b0},
    '{CH_ALL_ONES,        1'b0, 32'd0,        1'b0},
    '{"3",                1'b0, 32'd0,        1'b0},
    '{lrx_pkg::CH_NUL,    1'b1, 32'h80000000, 1'b0},
    '{"9",                1'b0, 32'd0,        1'b0},
    '{lrx_pkg::CH_MINUS,  1'b0, 32'd0,        1'b0},
    '{"3",                1'b0, 32'd0,        1'b0},
    '{lrx_pkg::CH_TIMES,  1'b0, 32'd0,        1'b0},
    '{"4",                1'b0, 32'd0,        1'b0},
    '{lrx_pkg::CH_DIVIDE, 1'b0, 32'd0,        1'b0},
    '{"0",                1'b0, 32'd0,        1'b0},
    '{lrx_pkg::CH_NUL,    1'b1, 32'd24,       1'b1}
  };

  left_to_right_expression_evaluator_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_symbol        (in_symbol),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_divide_error (out_divide_error)
  );

  always #2 clk = ~clk;

  function automatic void clear_totals();
    acc_total   = '0;
    acc_number  = '0;
    acc_op      = lrx_pkg::OP_PLUS;
    acc_div_err = 1'b0;
  endfunction

  // Advance the evaluator by one symbol; return 1 when a total is produced
  function automatic logic evaluate_symbol(input logic [lrx_pkg::SYM_W-1:0] sym,
                                           output total_t res);
    logic [lrx_pkg::VALUE_W-1:0] mag_a;
    logic [lrx_pkg::VALUE_W-1:0] mag_b;
    logic [lrx_pkg::VALUE_W-1:0] quo;
    res = '0;
    if (sym >= lrx_pkg::CH_ZERO && sym <= lrx_pkg::CH_NINE) begin
      acc_number = acc_number * 10 + (sym - lrx_pkg::CH_ZERO);
      return 1'b0;
    end
    case (acc_op)
      lrx_pkg::OP_PLUS:  acc_total = acc_total + acc_number;
      lrx_pkg::OP_MINUS: acc_total = acc_total - acc_number;
      lrx_pkg::OP_TIMES: acc_total = acc_total * acc_number;
      lrx_pkg::OP_DIVIDE: begin
        if (acc_number == '0) begin
          acc_div_err = 1'b1;
        end else begin
          // divide magnitudes, then restore the sign: truncates toward zero
          mag_a = acc_total[lrx_pkg::VALUE_W-1] ? -acc_total : acc_total;
          mag_b = acc_number[lrx_pkg::VALUE_W-1] ? -acc_number : acc_number;
          quo   = mag_a / mag_b;
          if (acc_total[lrx_pkg::VALUE_W-1] ^ acc_number[lrx_pkg::VALUE_W-1]) quo = -quo;
          acc_total = quo;
        end
      end
      default: ;
    endcase
    if (sym == lrx_pkg::CH_NUL) begin
      res.value   = acc_total;
      res.div_err = acc_div_err;
      clear_totals();
      return 1'b1;
    end
    case (sym)
      lrx_pkg::CH_PLUS:   acc_op = lrx_pkg::OP_PLUS;
      lrx_pkg::CH_MINUS:  acc_op = lrx_pkg::OP_MINUS;
      lrx_pkg::CH_TIMES:  acc_op = lrx_pkg::OP_TIMES;
      lrx_pkg::CH_DIVIDE: acc_op = lrx_pkg::OP_DIVIDE;
      default:            acc_op = lrx_pkg::OP_UNKNOWN;
    endcase
    acc_number = '0;
    return 1'b0;
  endfunction

  task automatic send_symbol(input logic [lrx_pkg::SYM_W-1:0] sym, input logic typed = 1'b0,
                             input total_t typed_res = '0);
    total_t res;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    in_symbol <= sym;
    do @(posedge clk); while (in_stall);
    if (evaluate_symbol(sym, res)) totals_due.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  // Hold the input until every total has come out
  task automatic drain_totals();
    in_valid <= 1'b0;
    do @(posedge clk); while (totals_due.size() != 0);
  endtask

  function automatic logic [lrx_pkg::SYM_W-1:0] pick_operator();
    logic [lrx_pkg::SYM_W-1:0] sym;
    if ($urandom_range(0, 99) < 85) begin
      case ($urandom_range(0, 3))
        0:       sym = lrx_pkg::CH_PLUS;
        1:       sym = lrx_pkg::CH_MINUS;
        2:       sym = lrx_pkg::CH_TIMES;
        default: sym = lrx_pkg::CH_DIVIDE;
      endcase
    end else begin
      do sym = lrx_pkg::SYM_W'($urandom_range(1, 255));
      while ((sym >= lrx_pkg::CH_ZERO && sym <= lrx_pkg::CH_NINE) ||
             sym == lrx_pkg::CH_PLUS || sym == lrx_pkg::CH_MINUS ||
             sym == lrx_pkg::CH_TIMES || sym == lrx_pkg::CH_DIVIDE);
    end
    return sym;
  endfunction

  task automatic send_number();
    int roll;
    int len;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      send_symbol(lrx_pkg::CH_ZERO);
    end else begin
      len = (roll < 70) ? $urandom_range(1, 3) :
            (roll < 92) ? $urandom_range(4, 9) : $urandom_range(10, 12);
      repeat (len)
        send_symbol(lrx_pkg::SYM_W'(lrx_pkg::CH_ZERO + $urandom_range(0, 9)));
    end
  endtask

  task automatic send_expression();
    int terms;
    terms = $urandom_range(1, 6);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) send_symbol(pick_operator());
      if ($urandom_range(0, 99) >= 5) send_number();
    end
    send_symbol(lrx_pkg::CH_NUL);
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

  always @(posedge clk) begin : check_totals
    total_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (totals_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected total: value %0d divide_error %0b", out_value, out_divide_error);
      end else begin
        want = totals_due.pop_front();
        if (out_value !== want.value || out_divide_error !== want.div_err) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("total mismatch: expected %0d/%0b, got %0d/%0b",
                     $signed(want.value), want.div_err, out_value, out_divide_error);
        end
      end
    end
  end

  initial begin
    int base;
    clear_totals();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n          <= 1'b1;
    send_idle_pct  = 29;
    recv_stall_pct = 82;
    foreach (directed_rows[k])
      send_symbol(directed_rows[k].sym, directed_rows[k].typed,
                  total_t'{directed_rows[k].value, directed_rows[k].div_err});
    drain_totals();
    base = items_sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 29; recv_stall_pct = 82; end
        1:       begin send_idle_pct = 82; recv_stall_pct = 29; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      while (items_sent < base + (phase + 1) * ITEM_TARGET / 3) begin
        if ($urandom_range(0, 99) < 10)
          repeat ($urandom_range(1, 8)) send_symbol(lrx_pkg::SYM_W'($urandom_range(0, 255)));
        else
          send_expression();
      end
      if (phase == 0) drain_totals();
    end
    // close any expression left open by noise
    send_symbol(lrx_pkg::CH_NUL);
    in_valid <= 1'b0;
    while (totals_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && totals_due.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
